// File: hw/rtl/hdlcdf_pkg.sv
// Shared types and byte constants for the HDLC byte-unstuffing deframer.
// No dependencies; imported by the deframer top level.
package hdlcdf_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_OF_ESC  = 8'h5D;
  localparam logic [7:0] ESC_OF_FLAG = 8'h5E;

  // Kind code carried with every result word.
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_LOST       = 2'd1,
    KIND_BAD_ESCAPE = 2'd2,
    KIND_OVERFLOW   = 2'd3
  } kind_t;

  // Register map: byte address of each configuration register.
  localparam logic [2:0] ADDR_MAX_FRAME_LENGTH = 3'd0;

endpackage

// File: hw/rtl/hdlcdf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// The read data register holds its value while no read is requested.
module hdlcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hdlc_byte_unstuff_deframer_top.sv
// HDLC byte-unstuffing deframer: hunts for a flag, removes escapes, buffers
// a frame in hdlcdf_ram and bursts it out on the next flag. Uses hdlcdf_pkg.
//
//   channel  direction  words                           handshake
//   in       input      in_rx_byte                      in_valid / in_ready
//   out      output     out_kind, out_byte_value,       out_valid / out_ready
//                       out_frame_end
//   cfg      input      APB write/read of max length    psel/penable, pready=1
//
// A received byte is accepted when the output register is free or being
// taken. A closing flag of an N-byte frame holds input off until the last of
// its N words enters the output register; meanwhile the frame memory is read
// out one word per cycle, unless out_ready stalls, through its registered
// read port and the output register. After reset the block hunts for a flag
// at once; frame memory needs no clearing since only written entries are read.
module hdlc_byte_unstuff_deframer_top
  import hdlcdf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic        out_frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW   = $clog2(MAX_FRAME_BYTES);
  localparam int CW   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic {
    ST_RUN,
    ST_SEND
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  max_len_r;
  logic        in_frame_r, in_frame_nxt;
  logic        esc_r, esc_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic        rd_valid_r, rd_valid_nxt;
  logic        rd_last_r, rd_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;

  logic          in_fire, cfg_write, move1, ram_re, ram_we;
  logic [7:0]    ram_rdata, store_val;
  logic          store_req;
  logic [CMPW-1:0] cfg_ext, cap_ext, limit, count_ext;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_MAX_FRAME_LENGTH) ? {25'd0, max_len_r} : 32'd0;

  assign in_ready = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Limit 0, or any limit above the buffer size, means the whole buffer.
  assign cfg_ext   = CMPW'(max_len_r);
  assign cap_ext   = CMPW'(MAX_FRAME_BYTES);
  assign limit     = (cfg_ext == '0 || cfg_ext > cap_ext) ? cap_ext : cfg_ext;
  assign count_ext = CMPW'(count_r);

  // Readout pipeline: RAM read register is the first stage, output register
  // the second.
  assign move1  = (state_r == ST_SEND) && rd_valid_r && (!out_valid_r || out_ready);
  assign ram_re = (state_r == ST_SEND) && (rd_idx_r != count_r)
                  && (!rd_valid_r || move1);

  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_valid_nxt  = rd_valid_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    store_req     = 1'b0;
    store_val     = in_rx_byte;
    ram_we        = 1'b0;

    if (in_fire) begin
      if (!in_frame_r) begin
        if (in_rx_byte == FLAG_BYTE) begin
          in_frame_nxt = 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LOST;
          out_byte_nxt  = in_rx_byte;
          out_end_nxt   = 1'b0;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        priority if (in_rx_byte == ESC_OF_ESC) begin
          store_req = 1'b1;
          store_val = ESC_BYTE;
        end else if (in_rx_byte == ESC_OF_FLAG) begin
          store_req = 1'b1;
          store_val = FLAG_BYTE;
        end else begin
          count_nxt     = '0;
          in_frame_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BAD_ESCAPE;
          out_byte_nxt  = in_rx_byte;
          out_end_nxt   = 1'b0;
        end
      end else if (in_rx_byte == FLAG_BYTE) begin
        if (count_r != '0) begin
          state_nxt    = ST_SEND;
          rd_idx_nxt   = '0;
          rd_valid_nxt = 1'b0;
        end
      end else if (in_rx_byte == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        store_req = 1'b1;
      end

      if (store_req) begin
        if (count_ext >= limit) begin
          count_nxt     = '0;
          in_frame_nxt  = 1'b0;
          esc_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_OVERFLOW;
          out_byte_nxt  = store_val;
          out_end_nxt   = 1'b0;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
    end

    if (state_r == ST_SEND) begin
      if (move1) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_DATA;
        out_byte_nxt  = ram_rdata;
        out_end_nxt   = rd_last_r;
        rd_valid_nxt  = 1'b0;
        if (rd_last_r) begin
          state_nxt = ST_RUN;
          count_nxt = '0;
        end
      end
      if (ram_re) begin
        rd_valid_nxt = 1'b1;
        rd_last_nxt  = (rd_idx_r + CW'(1)) == count_r;
        rd_idx_nxt   = rd_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      max_len_r   <= '0;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_valid_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
      out_byte_r  <= out_byte_nxt;
      out_end_r   <= out_end_nxt;
      if (cfg_write && paddr == ADDR_MAX_FRAME_LENGTH) begin
        max_len_r <= pwdata[6:0];
      end
    end
  end

  hdlcdf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(store_val),
    .re   (ram_re),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_byte_value = out_byte_r;
  assign out_frame_end  = out_end_r;

  // The fill count can never pass the buffer size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= cap_ext)
    else $error("frame count beyond buffer size");

  // The frame memory is never written while it is being read out.
  a_no_write_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_RUN)
    else $error("frame memory written during readout");

  // Reads never run ahead of the stored frame.
  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |-> rd_idx_r <= count_r)
    else $error("read index beyond frame length");

  // A frame end marker only ever travels with a data word.
  a_end_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_kind_r == KIND_DATA)
    else $error("frame end on a non-data word");

endmodule
